// File: hw/rtl/bilinear_grid_interpolator_macros.svh
// Assertion macros for the bilinear grid interpolator.
`ifndef BILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define BILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BGI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BGI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bgi_pkg.sv
// Shared types and constants for the bilinear grid interpolator.
package bgi_pkg;

	localparam int ROWS_DEF  = 128;
	localparam int COLS_DEF  = 128;
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef logic [3:0][31:0] vals_t;

	typedef struct packed {
		logic        func;
		logic [13:0] entry_index;
		logic [31:0] q2;
		logic [16:0] x;
		logic [31:0] g1p_value;
		logic [31:0] g2p_value;
		logic [31:0] g1n_value;
		logic [31:0] g2n_value;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [31:0] g1p_interp;
		logic [31:0] g2p_interp;
		logic [31:0] g1n_interp;
		logic [31:0] g2n_interp;
	} rsp_t;

	typedef struct packed {
		logic [31:0] q2;
		logic [16:0] x;
		vals_t       g;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_LO, ST_RD_HI, ST_RD_XH, ST_WAIT_XH, ST_CHK,
		ST_SCAN_R, ST_SCAN_C, ST_RD_QR0, ST_RD_QR1, ST_RD_XC0, ST_RD_XC1,
		ST_RD_V00, ST_RD_V01, ST_RD_V10, ST_RD_V11,
		ST_FRAC_X, ST_DIV_X, ST_FRAC_Q, ST_DIV_Q, ST_BLEND, ST_WAIT_B
	} state_t;

	typedef enum logic [3:0] {
		TG_NONE, TG_LO, TG_HI, TG_XH, TG_ROW, TG_COL, TG_QR0, TG_QR1,
		TG_XC0, TG_XC1, TG_V00, TG_V01, TG_V10, TG_V11
	} tag_t;

endpackage

// File: hw/rtl/bgi_table.sv
// Grid table memory: one write port, one registered read port.
module bgi_table #(
	parameter int DEPTH = bgi_pkg::ROWS_DEF * bgi_pkg::COLS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  bgi_pkg::entry_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output bgi_pkg::entry_t  rdata
);

	bgi_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/bgi_div.sv
// Restoring divider producing a Q0.16 fraction one bit per cycle.
module bgi_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic        done,
	output logic [bgi_pkg::FRAC_BITS-1:0] quo
);

	localparam int CNTW = $clog2(bgi_pkg::FRAC_BITS + 1);

	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic [bgi_pkg::FRAC_BITS-1:0] quo_q;
	logic [CNTW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   rem2;
	logic          ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CNTW'(cnt_q + 1'b1);
				if (cnt_q == CNTW'(bgi_pkg::FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
			quo_q <= {quo_q[bgi_pkg::FRAC_BITS-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hw/rtl/bgi_blend.sv
// Bilinear blend of four corner value sets on one shared multiplier.
module bgi_blend (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [16:0]    tx,
	input  logic [16:0]    tq,
	input  bgi_pkg::vals_t v00,
	input  bgi_pkg::vals_t v01,
	input  bgi_pkg::vals_t v10,
	input  bgi_pkg::vals_t v11,
	output logic           done,
	output bgi_pkg::vals_t res
);

	logic        busy_q;
	logic        done_q;
	logic [1:0]  k_q;
	logic [1:0]  j_q;
	logic        ph_q;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [51:0] prod_s1;
	logic signed [49:0] a0_q;
	logic signed [50:0] diff_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] sum;
	logic signed [33:0] rnd;
	logic [31:0]        sat;
	bgi_pkg::vals_t     res_q;

	always_comb begin
		case (j_q)
			2'd0: begin
				mul_a = 34'($signed(v01[k_q])) - 34'($signed(v00[k_q]));
				mul_b = $signed({1'b0, tx});
			end
			2'd1: begin
				mul_a = 34'($signed(v11[k_q])) - 34'($signed(v10[k_q]));
				mul_b = $signed({1'b0, tx});
			end
			2'd2: begin
				mul_a = $signed({9'd0, diff_q[24:0]});
				mul_b = $signed({1'b0, tq});
			end
			default: begin
				mul_a = 34'(diff_q >>> 25);
				mul_b = $signed({1'b0, tq});
			end
		endcase
	end

	assign sum = acc_q + (66'(prod_s1) <<< 25) + 66'sd2147483648;
	assign rnd = 34'(sum >>> 32);

	always_comb begin
		if (rnd > 34'sd2147483647) begin
			sat = 32'h7FFF_FFFF;
		end else if (rnd < -34'sd2147483648) begin
			sat = 32'h8000_0000;
		end else begin
			sat = rnd[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			j_q    <= '0;
			ph_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				j_q    <= '0;
				ph_q   <= 1'b0;
			end else if (busy_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					j_q <= 2'(j_q + 1'b1);
					if (j_q == 2'd3) begin
						k_q <= 2'(k_q + 1'b1);
						if (k_q == 2'd3) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !ph_q) begin
			prod_s1 <= mul_a * mul_b;
		end
		if (busy_q && ph_q) begin
			case (j_q)
				2'd0: a0_q <= (50'($signed(v00[k_q])) <<< 16) + 50'(prod_s1);
				2'd1: diff_q <= (51'($signed(v10[k_q])) <<< 16) + 51'(prod_s1) - 51'(a0_q);
				2'd2: acc_q <= (66'(a0_q) <<< 16) + 66'(prod_s1);
				default: res_q[k_q] <= sat;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: hw/rtl/bilinear_grid_interpolator.sv
// Top level of the bilinear grid interpolator: sequencer around the grid table.
// Load: written at the transfer, result strobe in the following cycle; a new item may follow.
// Query: the single read port scans every row and every column but the first, then up to
// two divides and a blend on one multiplier run before the strobe; out of range strobes
// after the range check. Next transfer at strobe.
// Reset clears the sequencer only; table contents are undefined until loaded.
module bilinear_grid_interpolator #(
	parameter int ROWS = bgi_pkg::ROWS_DEF,
	parameter int COLS = bgi_pkg::COLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bgi_pkg::req_t req,
	output logic          done,
	output bgi_pkg::rsp_t rsp
);

	localparam int ENTRIES = ROWS * COLS;
	localparam int AW = $clog2(ENTRIES);
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam int IW = (RW > CW) ? RW : CW;

	bgi_pkg::state_t state_q, state_d;
	bgi_pkg::tag_t   rd_tag, rd_tag_s1;
	bgi_pkg::entry_t wdata, rdata;

	logic          we, rd_en;
	logic [AW-1:0] rd_addr;
	logic          div_start, div_busy, div_done;
	logic [31:0]   div_num, div_den;
	logic [bgi_pkg::FRAC_BITS-1:0] div_quo;
	logic          blend_start, blend_done;
	bgi_pkg::vals_t blend_res;

	logic [31:0]   qq_q, lo_q2_q, hi_q2_q, qr0_q, qr1_q;
	logic [16:0]   qx_q, x0_q, xh_q, xc0_q, xc1_q, tx_q, tq_q;
	logic [RW-1:0] rcnt_q, r0_q, r0c;
	logic [CW-1:0] ccnt_q, c1_q, c0;
	logic [AW-1:0] raddr_q, row0_addr;
	logic          found_q;
	logic [IW-1:0] rd_idx_s1;
	bgi_pkg::vals_t v00_q, v01_q, v10_q, v11_q;
	logic          done_q;
	bgi_pkg::rsp_t rsp_q;

	logic oor, fx_div, fx_one, fx_zero, fq_div, fq_one, fq_zero;

	assign busy = state_q != bgi_pkg::ST_IDLE;
	assign we   = start && !busy && !req.func && (32'(req.entry_index) < 32'(ENTRIES));
	assign wdata = '{q2: req.q2, x: req.x,
		g: {req.g2n_value, req.g1n_value, req.g2p_value, req.g1p_value}};

	assign r0c = (r0_q > RW'(ROWS - 2)) ? RW'(ROWS - 2) : r0_q;
	assign row0_addr = AW'(AW'(r0c) * AW'(COLS));
	assign c0 = CW'(c1_q - CW'(1));

	assign oor = (qq_q < lo_q2_q) || (qq_q > hi_q2_q) || (qx_q < x0_q) || (qx_q > xh_q);
	assign fx_zero = (xc1_q <= xc0_q) || (qx_q <= xc0_q);
	assign fx_one  = !fx_zero && (qx_q >= xc1_q);
	assign fx_div  = !fx_zero && !fx_one;
	assign fq_zero = (qr1_q <= qr0_q) || (qq_q <= qr0_q);
	assign fq_one  = !fq_zero && (qq_q >= qr1_q);
	assign fq_div  = !fq_zero && !fq_one;

	bgi_table #(.DEPTH(ENTRIES), .AW(AW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(req.entry_index)),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	bgi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	bgi_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.tx     (tx_q),
		.tq     (tq_q),
		.v00    (v00_q),
		.v01    (v01_q),
		.v10    (v10_q),
		.v11    (v11_q),
		.done   (blend_done),
		.res    (blend_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bgi_pkg::ST_IDLE:    if (start && req.func) state_d = bgi_pkg::ST_RD_LO;
			bgi_pkg::ST_RD_LO:   state_d = bgi_pkg::ST_RD_HI;
			bgi_pkg::ST_RD_HI:   state_d = bgi_pkg::ST_RD_XH;
			bgi_pkg::ST_RD_XH:   state_d = bgi_pkg::ST_WAIT_XH;
			bgi_pkg::ST_WAIT_XH: state_d = bgi_pkg::ST_CHK;
			bgi_pkg::ST_CHK:     state_d = oor ? bgi_pkg::ST_IDLE : bgi_pkg::ST_SCAN_R;
			bgi_pkg::ST_SCAN_R:  if (rcnt_q == RW'(ROWS - 1)) state_d = bgi_pkg::ST_SCAN_C;
			bgi_pkg::ST_SCAN_C:  if (ccnt_q == CW'(COLS - 1)) state_d = bgi_pkg::ST_RD_QR0;
			bgi_pkg::ST_RD_QR0:  state_d = bgi_pkg::ST_RD_QR1;
			bgi_pkg::ST_RD_QR1:  state_d = bgi_pkg::ST_RD_XC0;
			bgi_pkg::ST_RD_XC0:  state_d = bgi_pkg::ST_RD_XC1;
			bgi_pkg::ST_RD_XC1:  state_d = bgi_pkg::ST_RD_V00;
			bgi_pkg::ST_RD_V00:  state_d = bgi_pkg::ST_RD_V01;
			bgi_pkg::ST_RD_V01:  state_d = bgi_pkg::ST_RD_V10;
			bgi_pkg::ST_RD_V10:  state_d = bgi_pkg::ST_RD_V11;
			bgi_pkg::ST_RD_V11:  state_d = bgi_pkg::ST_FRAC_X;
			bgi_pkg::ST_FRAC_X:  state_d = fx_div ? bgi_pkg::ST_DIV_X : bgi_pkg::ST_FRAC_Q;
			bgi_pkg::ST_DIV_X:   if (div_done) state_d = bgi_pkg::ST_FRAC_Q;
			bgi_pkg::ST_FRAC_Q:  state_d = fq_div ? bgi_pkg::ST_DIV_Q : bgi_pkg::ST_BLEND;
			bgi_pkg::ST_DIV_Q:   if (div_done) state_d = bgi_pkg::ST_BLEND;
			bgi_pkg::ST_BLEND:   state_d = bgi_pkg::ST_WAIT_B;
			bgi_pkg::ST_WAIT_B:  if (blend_done) state_d = bgi_pkg::ST_IDLE;
			default:             state_d = bgi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en       = 1'b1;
		rd_addr     = '0;
		rd_tag      = bgi_pkg::TG_NONE;
		div_start   = 1'b0;
		div_num     = 32'(qx_q - xc0_q);
		div_den     = 32'(xc1_q - xc0_q);
		blend_start = 1'b0;
		case (state_q)
			bgi_pkg::ST_RD_LO: rd_tag = bgi_pkg::TG_LO;
			bgi_pkg::ST_RD_HI: begin
				rd_addr = AW'(ENTRIES - 1);
				rd_tag  = bgi_pkg::TG_HI;
			end
			bgi_pkg::ST_RD_XH: begin
				rd_addr = AW'(COLS - 1);
				rd_tag  = bgi_pkg::TG_XH;
			end
			bgi_pkg::ST_SCAN_R: begin
				rd_addr = raddr_q;
				rd_tag  = bgi_pkg::TG_ROW;
			end
			bgi_pkg::ST_SCAN_C: begin
				rd_addr = AW'(ccnt_q);
				rd_tag  = bgi_pkg::TG_COL;
			end
			bgi_pkg::ST_RD_QR0: begin
				rd_addr = row0_addr;
				rd_tag  = bgi_pkg::TG_QR0;
			end
			bgi_pkg::ST_RD_QR1: begin
				rd_addr = AW'(row0_addr + AW'(COLS));
				rd_tag  = bgi_pkg::TG_QR1;
			end
			bgi_pkg::ST_RD_XC0: begin
				rd_addr = AW'(c0);
				rd_tag  = bgi_pkg::TG_XC0;
			end
			bgi_pkg::ST_RD_XC1: begin
				rd_addr = AW'(c1_q);
				rd_tag  = bgi_pkg::TG_XC1;
			end
			bgi_pkg::ST_RD_V00: begin
				rd_addr = AW'(row0_addr + AW'(c0));
				rd_tag  = bgi_pkg::TG_V00;
			end
			bgi_pkg::ST_RD_V01: begin
				rd_addr = AW'(row0_addr + AW'(c1_q));
				rd_tag  = bgi_pkg::TG_V01;
			end
			bgi_pkg::ST_RD_V10: begin
				rd_addr = AW'(row0_addr + AW'(COLS) + AW'(c0));
				rd_tag  = bgi_pkg::TG_V10;
			end
			bgi_pkg::ST_RD_V11: begin
				rd_addr = AW'(row0_addr + AW'(COLS) + AW'(c1_q));
				rd_tag  = bgi_pkg::TG_V11;
			end
			bgi_pkg::ST_FRAC_X: begin
				rd_en     = 1'b0;
				div_start = fx_div;
			end
			bgi_pkg::ST_FRAC_Q: begin
				rd_en     = 1'b0;
				div_start = fq_div;
				div_num   = qq_q - qr0_q;
				div_den   = qr1_q - qr0_q;
			end
			bgi_pkg::ST_BLEND: begin
				rd_en       = 1'b0;
				blend_start = 1'b1;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bgi_pkg::ST_IDLE;
			rd_tag_s1 <= bgi_pkg::TG_NONE;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_tag_s1 <= rd_tag;
			done_q    <= (start && !busy && !req.func)
				|| (state_q == bgi_pkg::ST_CHK && oor)
				|| (state_q == bgi_pkg::ST_WAIT_B && blend_done);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= (state_q == bgi_pkg::ST_SCAN_R) ? IW'(rcnt_q) : IW'(ccnt_q);
		if (start && !busy) begin
			qq_q  <= req.q2;
			qx_q  <= req.x;
			rsp_q <= '0;
		end
		case (state_q)
			bgi_pkg::ST_CHK: begin
				rcnt_q  <= '0;
				raddr_q <= '0;
				ccnt_q  <= CW'(1);
				r0_q    <= '0;
				c1_q    <= CW'(COLS - 1);
				found_q <= 1'b0;
				if (oor) begin
					rsp_q.status <= 1'b1;
				end
			end
			bgi_pkg::ST_SCAN_R: begin
				rcnt_q  <= RW'(rcnt_q + 1'b1);
				raddr_q <= AW'(raddr_q + AW'(COLS));
			end
			bgi_pkg::ST_SCAN_C: ccnt_q <= CW'(ccnt_q + 1'b1);
			bgi_pkg::ST_FRAC_X: tx_q <= fx_one ? bgi_pkg::ONE_Q16 : '0;
			bgi_pkg::ST_DIV_X:  if (div_done) tx_q <= {1'b0, div_quo};
			bgi_pkg::ST_FRAC_Q: tq_q <= fq_one ? bgi_pkg::ONE_Q16 : '0;
			bgi_pkg::ST_DIV_Q:  if (div_done) tq_q <= {1'b0, div_quo};
			bgi_pkg::ST_WAIT_B: begin
				if (blend_done) begin
					rsp_q.status     <= 1'b0;
					rsp_q.g1p_interp <= blend_res[0];
					rsp_q.g2p_interp <= blend_res[1];
					rsp_q.g1n_interp <= blend_res[2];
					rsp_q.g2n_interp <= blend_res[3];
				end
			end
			default: ;
		endcase
		case (rd_tag_s1)
			bgi_pkg::TG_LO: begin
				lo_q2_q <= rdata.q2;
				x0_q    <= rdata.x;
			end
			bgi_pkg::TG_HI:  hi_q2_q <= rdata.q2;
			bgi_pkg::TG_XH:  xh_q <= rdata.x;
			bgi_pkg::TG_ROW: if (rdata.q2 <= qq_q) r0_q <= RW'(rd_idx_s1);
			bgi_pkg::TG_COL: begin
				if (!found_q && rdata.x > qx_q) begin
					c1_q    <= CW'(rd_idx_s1);
					found_q <= 1'b1;
				end
			end
			bgi_pkg::TG_QR0: qr0_q <= rdata.q2;
			bgi_pkg::TG_QR1: qr1_q <= rdata.q2;
			bgi_pkg::TG_XC0: xc0_q <= rdata.x;
			bgi_pkg::TG_XC1: xc1_q <= rdata.x;
			bgi_pkg::TG_V00: v00_q <= rdata.g;
			bgi_pkg::TG_V01: v01_q <= rdata.g;
			bgi_pkg::TG_V10: v10_q <= rdata.g;
			bgi_pkg::TG_V11: v11_q <= rdata.g;
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`include "bilinear_grid_interpolator_macros.svh"

	`BGI_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a query is in flight")
	`BGI_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted item dropped")
	`BGI_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider restarted while busy")
	`BGI_ASSERT_NOW(a_blend_only_wait, blend_done, state_q == bgi_pkg::ST_WAIT_B,
		"blend finished outside its wait state")

endmodule
